// ===== rtl/fpp_pkg.sv =====
// ----------------------------------------------------------------------------
// fpp_pkg: shared types and constants of the fixed-point power unit
// Word types for both channels, divider sizes and Q16.16 coefficients.
// ----------------------------------------------------------------------------
package fpp_pkg;

    typedef struct packed {
        logic signed [31:0] base;
        logic signed [31:0] exponent;
    } pow_arg_t;

    typedef struct packed {
        logic signed [31:0] power;
        logic               bad_base;
    } pow_res_t;

    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 32;
    localparam int HORNER_STEPS = 4;

    localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_8    = 32'h0008_0000;
    localparam logic [31:0] Q_16   = 32'h0010_0000;
    localparam int          EXP_WHOLE_MAX = 14;

    localparam logic signed [31:0] LA4 = -32'sd155;
    localparam logic signed [31:0] LA_ADD [HORNER_STEPS] =
        '{32'sd3433, -32'sd29124, 32'sd129995, -32'sd103029};
    localparam logic signed [31:0] LB_ADD [HORNER_STEPS] =
        '{32'sd20, -32'sd1077, 32'sd24968, 32'sd55468};

    localparam logic [15:0] E2 = 16'd22544;
    localparam logic [15:0] E1 = 16'd42667;
    localparam logic [16:0] E0 = 17'd65698;

    function automatic logic [31:0] sat_quo(input logic [DIV_NUM_W-1:0] q);
        logic [31:0] r;
        r = (q > DIV_NUM_W'(Q_MAX)) ? Q_MAX : q[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/fixed_point_power.sv =====
// ----------------------------------------------------------------------------
// fixed_point_power: Q16.16 power unit, base^exponent = exp2(exponent*log2(base))
// One word per cycle from accepted word to result word while the result is not stalled.
// Throughput is set by the fully pipelined dividers (one quotient bit per stage).
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset clears every valid bit; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module fixed_point_power
    import fpp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     arg_valid,
    output logic     arg_stall,
    input  pow_arg_t arg,
    output logic     res_valid,
    input  logic     res_stall,
    output pow_res_t res
);

    typedef struct packed {
        logic               bad;
        logic               below_one;
        logic [31:0]        a;
        logic signed [31:0] b;
    } side1_t;

    typedef struct packed {
        logic               bad;
        logic               neg;
        logic               big;
        logic               polyb;
        logic [31:0]        lgbig;
        logic [31:0]        x;
        logic signed [31:0] b;
    } hside_t;

    typedef struct packed {
        logic        bad;
        logic        neg;
        logic [31:0] p;
    } side2_t;

    logic en;

    // input stage
    logic               v1_reg;
    logic signed [31:0] a1_reg;
    logic signed [31:0] b1_reg;
    side1_t             side1_next;
    logic               dv1;
    logic [DIV_NUM_W-1:0] q1;
    side1_t             side1_out;

    // range reduction and log2
    logic               v2_reg;
    logic [31:0]        x2_reg;
    logic               bad2_reg;
    logic               neg2_reg;
    logic signed [31:0] b2_reg;
    logic [4:0]         msb;
    hside_t             hs3_next;

    logic               hv  [HORNER_STEPS+1];
    logic signed [31:0] hr  [HORNER_STEPS+1];
    hside_t             hs  [HORNER_STEPS+1];
    logic               v3_reg;
    logic signed [31:0] r3_reg;
    hside_t             hs3_reg;

    // product
    logic               v8_reg;
    logic signed [31:0] lg8_reg;
    logic signed [31:0] lg8_next;
    logic signed [31:0] b8_reg;
    logic               bad8_reg;
    logic               v9_reg;
    logic signed [63:0] p9_reg;
    logic               bad9_reg;
    logic signed [47:0] sh10;
    logic [47:0]        mag10;
    logic               v10_reg;
    logic [30:0]        y10_reg;
    logic               neg10_reg;
    logic               bad10_reg;

    // exp2
    logic [31:0]        m11;
    logic               v11_reg;
    logic [16:0]        t1_reg;
    logic [15:0]        frac11_reg;
    logic [14:0]        whole11_reg;
    logic               neg11_reg;
    logic               bad11_reg;
    logic [32:0]        m12;
    logic               v12_reg;
    logic [17:0]        t2_reg;
    logic [14:0]        whole12_reg;
    logic               neg12_reg;
    logic               bad12_reg;
    logic [32:0]        shifted13;
    logic               v13_reg;
    logic [31:0]        p13_reg;
    logic [31:0]        p13_next;
    logic               neg13_reg;
    logic               bad13_reg;
    side2_t             side2_next;
    logic               dv2;
    logic [DIV_NUM_W-1:0] q2;
    side2_t             side2_out;

    logic               res_valid_reg;
    pow_res_t           res_reg;
    pow_res_t           res_next;

    assign en        = !(res_valid_reg && res_stall);
    assign arg_stall = res_valid_reg && res_stall;

    // stage 1: capture word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= arg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= arg.base;
            b1_reg <= arg.exponent;
        end
    end

    always_comb
    begin
        side1_next.bad       = (a1_reg <= 32'sd0);
        side1_next.below_one = (a1_reg > 32'sd0) && (a1_reg < $signed(Q_ONE));
        side1_next.a         = a1_reg;
        side1_next.b         = b1_reg;
    end

    fpp_div #(
        .SIDE_W ($bits(side1_t))
    ) u_recip_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .num       ({2'b01, 1'b0, a1_reg[31:1]}),
        .den       (a1_reg),
        .side      (side1_next),
        .out_valid (dv1),
        .quo       (q1),
        .out_side  (side1_out)
    );

    // stage 2: pick log argument
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= dv1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg   <= side1_out.below_one ? sat_quo(q1) : side1_out.a;
            bad2_reg <= side1_out.bad;
            neg2_reg <= side1_out.below_one;
            b2_reg   <= side1_out.b;
        end
    end

    // stage 3: leading one and polynomial select
    always_comb
    begin
        msb = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (x2_reg[i])
            begin
                msb = 5'(i);
            end
        end
        hs3_next.bad   = bad2_reg;
        hs3_next.neg   = neg2_reg;
        hs3_next.big   = (x2_reg > Q_16);
        hs3_next.polyb = (x2_reg > Q_8);
        hs3_next.lgbig = {11'b0, 5'(msb - 5'd16), 16'b0};
        hs3_next.x     = x2_reg;
        hs3_next.b     = b2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r3_reg  <= (x2_reg > Q_8) ? 32'sd0 : LA4;
            hs3_reg <= hs3_next;
        end
    end

    assign hv[0] = v3_reg;
    assign hr[0] = r3_reg;
    assign hs[0] = hs3_reg;

    // stages 4 to 7: Horner steps
    for (genvar s = 0; s < HORNER_STEPS; s++)
    begin : g_horner
        logic signed [63:0] m;
        logic signed [31:0] r_next;
        logic               valid_reg;
        logic signed [31:0] r_reg;
        hside_t             side_reg;

        always_comb
        begin
            m      = hr[s] * $signed(hs[s].x);
            r_next = m[47:16] + (hs[s].polyb ? LB_ADD[s] : LA_ADD[s]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= hv[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg    <= r_next;
                side_reg <= hs[s];
            end
        end

        assign hv[s+1] = valid_reg;
        assign hr[s+1] = r_reg;
        assign hs[s+1] = side_reg;
    end

    // stage 8: signed logarithm
    always_comb
    begin
        lg8_next = hs[HORNER_STEPS].big ? $signed(hs[HORNER_STEPS].lgbig)
                                        : hr[HORNER_STEPS];
        if (hs[HORNER_STEPS].neg)
        begin
            lg8_next = -lg8_next;
        end
    end

    // stages 8 to 13
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
        end
        else if (en)
        begin
            v8_reg  <= hv[HORNER_STEPS];
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
        end
    end

    always_comb
    begin
        sh10      = p9_reg[63:16];
        mag10     = sh10[47] ? 48'(-sh10) : 48'(sh10);
        m11       = {16'b0, E2} * {16'b0, y10_reg[15:0]};
        m12       = 33'(t1_reg) * 33'(frac11_reg);
        shifted13 = 33'(t2_reg) << whole12_reg[3:0];
        p13_next  = ((whole12_reg > 15'(EXP_WHOLE_MAX)) || (shifted13 > 33'(Q_MAX)))
                  ? Q_MAX : shifted13[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg8_reg     <= lg8_next;
            b8_reg      <= hs[HORNER_STEPS].b;
            bad8_reg    <= hs[HORNER_STEPS].bad;

            p9_reg      <= lg8_reg * b8_reg;
            bad9_reg    <= bad8_reg;

            neg10_reg   <= sh10[47];
            y10_reg     <= (mag10 > 48'(Q_MAX)) ? Q_MAX[30:0] : mag10[30:0];
            bad10_reg   <= bad9_reg;

            t1_reg      <= 17'(m11[31:16]) + 17'(E1);
            frac11_reg  <= y10_reg[15:0];
            whole11_reg <= y10_reg[30:16];
            neg11_reg   <= neg10_reg;
            bad11_reg   <= bad10_reg;

            t2_reg      <= 18'(m12[32:16]) + 18'(E0);
            whole12_reg <= whole11_reg;
            neg12_reg   <= neg11_reg;
            bad12_reg   <= bad11_reg;

            p13_reg     <= p13_next;
            neg13_reg   <= neg12_reg;
            bad13_reg   <= bad12_reg;
        end
    end

    always_comb
    begin
        side2_next.bad = bad13_reg;
        side2_next.neg = neg13_reg;
        side2_next.p   = p13_reg;
    end

    fpp_div #(
        .SIDE_W ($bits(side2_t))
    ) u_recip_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v13_reg),
        .num       ({2'b01, 1'b0, p13_reg[31:1]}),
        .den       (p13_reg),
        .side      (side2_next),
        .out_valid (dv2),
        .quo       (q2),
        .out_side  (side2_out)
    );

    // output register
    always_comb
    begin
        res_next.bad_base = side2_out.bad;
        if (side2_out.bad)
        begin
            res_next.power = 32'sd0;
        end
        else if (side2_out.neg)
        begin
            res_next.power = sat_quo(q2);
        end
        else
        begin
            res_next.power = side2_out.p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= dv2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/fpp_div.sv =====
// ----------------------------------------------------------------------------
// fpp_div: pipelined restoring divider
// One quotient bit per stage; sideband travels alongside each word.
// ----------------------------------------------------------------------------
module fpp_div
    import fpp_pkg::*;
#(
    parameter int SIDE_W = 1
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    input  logic [SIDE_W-1:0]    side,
    output logic                 out_valid,
    output logic [DIV_NUM_W-1:0] quo,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int STAGES = DIV_NUM_W;

    logic                 st_valid [STAGES+1];
    logic [DIV_NUM_W-1:0] st_num   [STAGES+1];
    logic [DIV_NUM_W-1:0] st_quo   [STAGES+1];
    logic [DIV_DEN_W-1:0] st_rem   [STAGES+1];
    logic [DIV_DEN_W-1:0] st_den   [STAGES+1];
    logic [SIDE_W-1:0]    st_side  [STAGES+1];

    assign st_valid[0] = in_valid;
    assign st_num[0]   = num;
    assign st_quo[0]   = '0;
    assign st_rem[0]   = '0;
    assign st_den[0]   = den;
    assign st_side[0]  = side;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [DIV_DEN_W:0]   trial;
        logic [DIV_DEN_W:0]   diff;
        logic                 ge;
        logic [DIV_DEN_W-1:0] rem_next;
        logic                 valid_reg;
        logic [DIV_NUM_W-1:0] num_reg;
        logic [DIV_NUM_W-1:0] quo_reg;
        logic [DIV_DEN_W-1:0] rem_reg;
        logic [DIV_DEN_W-1:0] den_reg;
        logic [SIDE_W-1:0]    side_reg;

        always_comb
        begin
            trial    = {st_rem[s], st_num[s][DIV_NUM_W-1]};
            diff     = trial - {1'b0, st_den[s]};
            ge       = (trial >= {1'b0, st_den[s]});
            rem_next = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= st_valid[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg  <= {st_num[s][DIV_NUM_W-2:0], 1'b0};
                quo_reg  <= {st_quo[s][DIV_NUM_W-2:0], ge};
                rem_reg  <= rem_next;
                den_reg  <= st_den[s];
                side_reg <= st_side[s];
            end
        end

        assign st_valid[s+1] = valid_reg;
        assign st_num[s+1]   = num_reg;
        assign st_quo[s+1]   = quo_reg;
        assign st_rem[s+1]   = rem_reg;
        assign st_den[s+1]   = den_reg;
        assign st_side[s+1]  = side_reg;
    end

    assign out_valid = st_valid[STAGES];
    assign quo       = st_quo[STAGES];
    assign out_side  = st_side[STAGES];

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fixed-point power unit
// Drives base/exponent words with random gaps and output stalls, predicts each
// result in Q16.16 integer arithmetic and checks results in order.
// ----------------------------------------------------------------------------
module tb_top
    import fpp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QMAX = 64'h7fff_ffff;

    // floor shift right by 16 on a signed 64-bit product
    function automatic longint fsr16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint recip_q(longint d);
        longint q;
        if (d <= 0)
            return QMAX;
        q = ((64'sd1 << 32) + d / 2) / d;
        if (q > QMAX)
            q = QMAX;
        return q;
    endfunction

    function automatic longint log2_fix(longint x);
        longint r;
        int msb;
        if (x > (64'sd16 << 16))
        begin
            msb = 0;
            while (msb < 62 && (x >> (msb + 1)) != 0)
                msb++;
            return longint'(msb - 16) * 65536;
        end
        if (x > (64'sd8 << 16))
        begin
            r = 20;
            r = fsr16(r * x) - 1077;
            r = fsr16(r * x) + 24968;
            r = fsr16(r * x) + 55468;
            return r;
        end
        r = -155;
        r = fsr16(r * x) + 3433;
        r = fsr16(r * x) - 29124;
        r = fsr16(r * x) + 129995;
        r = fsr16(r * x) - 103029;
        return r;
    endfunction

    function automatic longint exp2_fix(longint y);
        longint whole;
        longint frac;
        longint t;
        longint p;
        whole = y >>> 16;
        frac = y & 64'hffff;
        if (whole > 14)
            return QMAX;
        t = 22544;
        t = fsr16(t * frac) + 42667;
        t = fsr16(t * frac) + 65698;
        p = fsr16((64'sd1 << (whole + 16)) * t);
        if (p > QMAX)
            p = QMAX;
        return p;
    endfunction

    function automatic pow_res_t predict_power(pow_arg_t w);
        pow_res_t r;
        longint a;
        longint b;
        longint lg;
        longint prod;
        longint pw;
        a = longint'(w.base);
        b = longint'(w.exponent);
        r.power = '0;
        r.bad_base = 1'b1;
        if (a <= 0)
            return r;
        if (a < 65536)
            lg = -log2_fix(recip_q(a));
        else
            lg = log2_fix(a);
        prod = fsr16(lg * b);
        if (prod > QMAX)
            prod = QMAX;
        if (prod < -QMAX)
            prod = -QMAX;
        if (prod < 0)
            pw = recip_q(exp2_fix(-prod));
        else
            pw = exp2_fix(prod);
        r.power = pw[31:0];
        r.bad_base = 1'b0;
        return r;
    endfunction

    class power_scoreboard;
        pow_res_t pending[$];
        int errors;

        function void note_arg(pow_arg_t w);
            pending.push_back(predict_power(w));
        endfunction

        function void check_res(pow_res_t got);
            pow_res_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result power=%h bad_base=%b",
                         $realtime, got.power, got.bad_base);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.power !== want.power)
            begin
                $display("%0t power: expected %h actual %h", $realtime, want.power, got.power);
                errors++;
            end
            if (got.bad_base !== want.bad_base)
            begin
                $display("%0t bad_base: expected %b actual %b",
                         $realtime, want.bad_base, got.bad_base);
                errors++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     arg_valid = 1'b0;
    logic     arg_stall;
    pow_arg_t arg = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    pow_res_t res;

    power_scoreboard sb = new();
    bit hold_res = 1'b0;
    bit sending_done = 1'b0;

    always #1 clk = ~clk;

    fixed_point_power i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (arg_valid),
        .arg_stall (arg_stall),
        .arg       (arg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 8)) - 4);
            2: return $urandom_range(1, 32'hffff);
            3: return $urandom_range(32'h1_0000, 32'h8_0000);
            4: return $urandom_range(32'h8_0001, 32'h10_0000);
            5: return $urandom_range(32'h10_0001, 32'h7fff_ffff);
            default: return $urandom_range(32'h4000, 32'h4_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_exp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 32'h40_0000)) - 32'sh20_0000);
            2: return 32'(int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
            default: return 32'(int'($urandom_range(0, 32'h1_0000)) - 32'sh8000);
        endcase
    endfunction

    task automatic send_word(logic [31:0] b, logic [31:0] e);
        arg_valid <= 1'b1;
        arg <= '{base: b, exponent: e};
        @(posedge clk);
        while (arg_stall)
            @(posedge clk);
        sb.note_arg(arg);
    endtask

    task automatic send_gap();
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            arg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender
    initial
    begin
        logic [31:0] bases[$];
        logic [31:0] exps[$];
        bases = '{32'h0000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001,
                  32'h0000_0002, 32'h0000_0003, 32'h0000_ffff, 32'h0001_0000,
                  32'h0008_0000, 32'h0008_0001, 32'h0010_0000, 32'h0010_0001,
                  32'h7fff_ffff, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                  32'h0002_0000, 32'h0000_8000, 32'h7fff_ffff, 32'h0003_8000};
        exps  = '{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                  32'h7fff_ffff, 32'hffff_0000, 32'h8000_0000, 32'h1234_5678,
                  32'h0000_0000, 32'h0001_8000, 32'hfffe_0000, 32'h0000_4000,
                  32'h8000_0000, 32'h000e_ffff, 32'h000f_0000, 32'h0010_0000,
                  32'hfff0_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (bases[i])
        begin
            send_word(bases[i], exps[i]);
            send_gap();
        end
        for (int n = 0; n < 600; n++)
        begin
            if (n == 200)
            begin
                arg_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            if (n == 300)
                hold_res = 1'b1;
            send_word(pick_base(), pick_exp());
            if (n < 300 || n > 420)
                send_gap();
        end
        arg_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_res)
            begin
                hold_res = 1'b0;
                gap = 300;
            end
            else
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            end
            if (gap > 0)
            begin
                res_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            sb.check_res(res);
        end
    end

    initial
    begin
        wait (sending_done);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/fpp_pkg.sv
rtl/fpp_div.sv
rtl/fixed_point_power.sv
tb/tb_top.sv
